// File: hdl/assert_macros.svh
// Concurrent assertion helpers for the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define STRAMP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("stepper ramp assertion failed");

// Check a property on every clock edge, reset included.
`define STRAMP_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("stepper ramp assertion failed");

`endif

// File: hdl/stramp_pkg.sv
package stramp_pkg;

   // Fixed field widths
   localparam int PERIOD_BITS      = 36;
   localparam int COEF_BITS        = 40;
   localparam int DECEL_STEPS_BITS = 31;
   localparam int ELAPSED_BITS     = 21;
   localparam int STEP_PERIOD_BITS = 20;
   localparam int CSR_INDEX_BITS   = 2;
   localparam int CSR_DATA_BITS    = 40;

   // Fixed-point formats
   localparam int PERIOD_FRAC_BITS = 16;
   localparam int ACCEL_FRAC_BITS  = 48;
   localparam int RAMP_SHIFT       = ACCEL_FRAC_BITS + 2 * PERIOD_FRAC_BITS;
   localparam int PERIOD_INT_BITS  = PERIOD_BITS - PERIOD_FRAC_BITS;
   localparam int TICK_CMP_BITS    =
      (ELAPSED_BITS > PERIOD_INT_BITS) ? ELAPSED_BITS : PERIOD_INT_BITS;
   localparam int OUT_CMP_BITS     =
      (STEP_PERIOD_BITS > PERIOD_INT_BITS) ? STEP_PERIOD_BITS : PERIOD_INT_BITS;
   localparam logic [STEP_PERIOD_BITS-1:0] STEP_PERIOD_MAX = '1;

   // Limb arithmetic of the shared multiplier
   localparam int LIMB_BITS = 32;
   localparam int PROD_BITS = 2 * LIMB_BITS;
   localparam int X_LIMBS   = 4;
   localparam int RES_LIMBS = 6;
   localparam int RES_BITS  = RES_LIMBS * LIMB_BITS;

   // Register reset values
   localparam logic [PERIOD_BITS-1:0]      START_PERIOD_RESET  = 36'd3276800000;
   localparam logic [PERIOD_BITS-1:0]      CRUISE_PERIOD_RESET = 36'd327680000;
   localparam logic [DECEL_STEPS_BITS-1:0] DECEL_STEPS_RESET   = 31'd100;
   localparam logic [COEF_BITS-1:0]        ACCEL_COEF_RESET    = 40'd56295;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_PERIOD  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CRUISE_PERIOD = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DECEL_STEPS   = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ACCEL_COEF    = 2'd3;

   typedef enum logic [1:0] {
      FUNC_TICK,
      FUNC_MOVE,
      FUNC_STOP,
      FUNC_SET
   } func_type;

   typedef struct packed {
      func_type           func;
      logic signed [31:0] position_value;
   } req_type;

   typedef struct packed {
      logic                        step_pulse;
      logic                        dir_negative;
      logic signed [31:0]          position_now;
      logic                        done_res;
      logic [STEP_PERIOD_BITS-1:0] step_period_now;
   } rsp_type;

   typedef struct packed {
      logic                   start;
      logic [PERIOD_BITS-1:0] period;
      logic [COEF_BITS-1:0]   coef;
   } cube_req_type;

   typedef struct packed {
      logic                   done;
      logic [PERIOD_BITS-1:0] delta;
   } cube_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_MUL_WAIT,
      ST_COMMIT
   } ctrl_state_type;

   typedef enum logic [1:0] {
      MS_IDLE,
      MS_RUN,
      MS_DRAIN,
      MS_NEXT
   } mul_state_type;

endpackage

// File: hdl/stramp_cube_mul.sv
module stramp_cube_mul
   import stramp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cube_req_type cube_req,
   output cube_rsp_type cube_rsp
);

   // Pass 0: p*p, pass 1: p^2*p, pass 2: p^3*coef
   localparam logic [1:0] LAST_PHASE   = 2'd2;
   localparam logic [1:0] COEF_PHASE   = 2'd2;
   localparam logic [2:0] BASE_X_LIMBS = 3'd2;

   mul_state_type           state_ff, state_in;
   logic [1:0]              phase_ff, phase_in;
   logic [2:0]              col_ff, col_in;
   logic                    sub_ff, sub_in;
   logic [PERIOD_BITS-1:0]  p_ff, p_in;
   logic [COEF_BITS-1:0]    a_ff, a_in;
   logic [LIMB_BITS-1:0]    x_ff [X_LIMBS];
   logic [LIMB_BITS-1:0]    x_in [X_LIMBS];
   logic [LIMB_BITS-1:0]    res_ff [RES_LIMBS];
   logic [LIMB_BITS-1:0]    res_in [RES_LIMBS];
   logic [PROD_BITS-1:0]    prod_ff, prod_in;
   logic                    prod_vld_ff, prod_vld_in;
   logic [2:0]              prod_col_ff, prod_col_in;
   logic                    prod_end_ff, prod_end_in;
   logic [PROD_BITS+1:0]    col_acc_ff, col_acc_in;
   logic [PERIOD_BITS-1:0]  delta_ff, delta_in;
   logic                    done_ff, done_in;

   logic [2:0]              x_count;
   logic [2:0]              row;
   logic                    slot_ok;
   logic                    last_slot;
   logic [LIMB_BITS-1:0]    x_limb;
   logic [COEF_BITS-1:0]    y_word;
   logic [LIMB_BITS-1:0]    y_limb;
   logic [PROD_BITS+1:0]    col_sum;
   logic [2:0]              next_col;
   logic [RES_BITS-1:0]     res_flat;
   logic                    overflow;
   logic [PERIOD_BITS-1:0]  delta_sat;

   // Pick the limb pair for the current slot (column scan, two rows per column)
   assign x_count   = 3'(phase_ff) + BASE_X_LIMBS;
   assign row       = col_ff - 3'(sub_ff);
   assign slot_ok   = sub_ff ? ((col_ff != 3'd0) && (col_ff <= x_count))
                             : (col_ff < x_count);
   assign last_slot = sub_ff && (col_ff == x_count);
   assign x_limb    = slot_ok ? x_ff[row[1:0]] : '0;
   assign y_word    = (phase_ff == COEF_PHASE) ? a_ff : COEF_BITS'(p_ff);
   assign y_limb    = sub_ff ? LIMB_BITS'(y_word[COEF_BITS-1:LIMB_BITS])
                             : y_word[LIMB_BITS-1:0];

   // Column accumulate of the registered product
   assign col_sum  = col_acc_ff + (PROD_BITS + 2)'(prod_ff);
   assign next_col = prod_col_ff + 3'd1;

   // Scale and saturate the final product
   always_comb begin
      for (int n = 0; n < RES_LIMBS; n++) begin
         res_flat[n*LIMB_BITS +: LIMB_BITS] = res_ff[n];
      end
   end
   assign overflow  = |(res_flat >> (RAMP_SHIFT + PERIOD_BITS));
   assign delta_sat = overflow ? '1 : res_flat[RAMP_SHIFT +: PERIOD_BITS];

   assign cube_rsp.done  = done_ff;
   assign cube_rsp.delta = delta_ff;

   // Sequencer and datapath next values
   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      col_in      = col_ff;
      sub_in      = sub_ff;
      p_in        = p_ff;
      a_in        = a_ff;
      x_in        = x_ff;
      res_in      = res_ff;
      prod_in     = prod_ff;
      prod_vld_in = 1'b0;
      prod_col_in = prod_col_ff;
      prod_end_in = prod_end_ff;
      col_acc_in  = col_acc_ff;
      delta_in    = delta_ff;
      done_in     = 1'b0;

      // fold in last cycle's product
      if (prod_vld_ff) begin
         if (prod_end_ff) begin
            res_in[prod_col_ff] = col_sum[LIMB_BITS-1:0];
            res_in[next_col]    = col_sum[PROD_BITS-1:LIMB_BITS];
            col_acc_in          = col_sum >> LIMB_BITS;
         end else begin
            col_acc_in = col_sum;
         end
      end

      unique case (state_ff)
         MS_IDLE: begin
            if (cube_req.start) begin
               p_in       = cube_req.period;
               a_in       = cube_req.coef;
               x_in[0]    = cube_req.period[LIMB_BITS-1:0];
               x_in[1]    = LIMB_BITS'(cube_req.period[PERIOD_BITS-1:LIMB_BITS]);
               x_in[2]    = '0;
               x_in[3]    = '0;
               phase_in   = '0;
               col_in     = '0;
               sub_in     = 1'b0;
               col_acc_in = '0;
               state_in   = MS_RUN;
            end
         end
         MS_RUN: begin
            prod_in     = PROD_BITS'(x_limb) * PROD_BITS'(y_limb);
            prod_vld_in = 1'b1;
            prod_col_in = col_ff;
            prod_end_in = sub_ff;
            if (sub_ff) begin
               sub_in = 1'b0;
               col_in = col_ff + 3'd1;
            end else begin
               sub_in = 1'b1;
            end
            if (last_slot) begin
               state_in = MS_DRAIN;
            end
         end
         MS_DRAIN: begin
            state_in = MS_NEXT;
         end
         MS_NEXT: begin
            col_acc_in = '0;
            if (phase_ff == LAST_PHASE) begin
               delta_in = delta_sat;
               done_in  = 1'b1;
               state_in = MS_IDLE;
            end else begin
               for (int n = 0; n < X_LIMBS; n++) begin
                  x_in[n] = res_ff[n];
               end
               phase_in = phase_ff + 2'd1;
               col_in   = '0;
               sub_in   = 1'b0;
               state_in = MS_RUN;
            end
         end
         default: begin
            state_in = MS_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= MS_IDLE;
         prod_vld_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         prod_vld_ff <= prod_vld_in;
         done_ff     <= done_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      phase_ff    <= phase_in;
      col_ff      <= col_in;
      sub_ff      <= sub_in;
      p_ff        <= p_in;
      a_ff        <= a_in;
      x_ff        <= x_in;
      res_ff      <= res_in;
      prod_ff     <= prod_in;
      prod_col_ff <= prod_col_in;
      prod_end_ff <= prod_end_in;
      col_acc_ff  <= col_acc_in;
      delta_ff    <= delta_in;
   end

endmodule

// File: hdl/stepper_trapezoid_ramp.sv
// Port    Dir  Handshake            Carries
// req     in   req_valid/req_ready  req_type: func, position_value
// rsp     out  rsp_valid/rsp_ready  rsp_type: step, direction, position, done, period
// csr     in   csr_we               csr_index, csr_data (write only)
//
// One item at a time. Move, stop, set position and ticks that do not step pass
// through decide and commit before the next acceptance. A tick that issues a step
// also waits for the ramp term coef*p^3, built by one shared 32x32 multiplier:
// 24 limb products over three passes, with drain and next states between passes.
// A waiting result stalls only the final commit; reset is synchronous and
// clears position, target, ramp state and the registers to their defaults.
module stepper_trapezoid_ramp
   import stramp_pkg::*;
#(
   parameter int POSITION_BITS = 32
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_data,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int DECEL_BITS =
      (POSITION_BITS - 1 > DECEL_STEPS_BITS) ? POSITION_BITS - 1 : DECEL_STEPS_BITS;
   localparam int SPAN_BITS =
      (POSITION_BITS > DECEL_STEPS_BITS + 1) ? POSITION_BITS : DECEL_STEPS_BITS + 1;
   localparam int REM_BITS =
      (POSITION_BITS > DECEL_BITS) ? POSITION_BITS : DECEL_BITS;

   // Motion state
   logic [POSITION_BITS-1:0]    position_ff, position_in;
   logic [POSITION_BITS-1:0]    target_ff, target_in;
   logic                        moving_neg_ff, moving_neg_in;
   logic [DECEL_BITS-1:0]       decel_point_ff, decel_point_in;
   logic [PERIOD_BITS-1:0]      next_period_ff, next_period_in;
   logic [PERIOD_BITS-1:0]      last_period_ff, last_period_in;
   logic [ELAPSED_BITS-1:0]     elapsed_ff, elapsed_in;
   logic                        decelerating_ff, decelerating_in;

   // Configuration
   logic [PERIOD_BITS-1:0]      start_period_ff, start_period_in;
   logic [PERIOD_BITS-1:0]      cruise_period_ff, cruise_period_in;
   logic [DECEL_STEPS_BITS-1:0] full_decel_ff, full_decel_in;
   logic [COEF_BITS-1:0]        accel_coef_ff, accel_coef_in;

   // Sequencer and item hold
   ctrl_state_type              state_ff, state_in;
   req_type                     item_ff, item_in;
   logic                        step_ff, step_in;
   logic                        at_decel_ff, at_decel_in;
   logic                        dist_neg_ff, dist_neg_in;
   logic [POSITION_BITS-1:0]    abs_dist_ff, abs_dist_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   rsp_type                     rsp_data_ff, rsp_data_in;
   rsp_type                     rsp_next;
   logic                        rsp_load;

   cube_req_type                cube_req;
   cube_rsp_type                cube_rsp;

   logic [POSITION_BITS+31:0]   pv_sext;
   logic [POSITION_BITS-1:0]    item_pos;
   logic [POSITION_BITS:0]      pos_x, pv_x, diff_up, diff_dn;
   logic                        dist_neg;
   logic [POSITION_BITS-1:0]    abs_dist;
   logic [POSITION_BITS-1:0]    remaining;
   logic                        at_decel;
   logic                        in_motion;
   logic [ELAPSED_BITS-1:0]     elapsed_inc;
   logic                        step_due;
   logic                        decel_next;
   logic [POSITION_BITS-1:0]    pos_stepped;
   logic [PERIOD_BITS:0]        period_sum;
   logic [PERIOD_BITS-1:0]      period_up, period_down, period_ramp, period_clamped;
   logic                        short_move;
   logic [DECEL_BITS-1:0]       decel_move;
   logic [POSITION_BITS-1:0]    stop_offset;
   logic                        slot_free;
   logic [POSITION_BITS+31:0]   pos_sext;
   logic [OUT_CMP_BITS-1:0]     period_int_out;

   stramp_cube_mul u_cube_mul (
      .clock    (clock),
      .reset    (reset),
      .cube_req (cube_req),
      .cube_rsp (cube_rsp)
   );

   // Input position and signed distance to it
   assign pv_sext  = {{POSITION_BITS{item_ff.position_value[31]}}, item_ff.position_value};
   assign item_pos = pv_sext[POSITION_BITS-1:0];
   assign pos_x    = {position_ff[POSITION_BITS-1], position_ff};
   assign pv_x     = {item_pos[POSITION_BITS-1], item_pos};
   assign diff_up  = pv_x - pos_x;
   assign diff_dn  = pos_x - pv_x;
   assign dist_neg = diff_up[POSITION_BITS];
   assign abs_dist = dist_neg ? diff_dn[POSITION_BITS-1:0] : diff_up[POSITION_BITS-1:0];

   // Distance left in the direction of motion
   assign remaining = moving_neg_ff ? (position_ff - target_ff) : (target_ff - position_ff);
   assign at_decel  = REM_BITS'(remaining) == REM_BITS'(decel_point_ff);
   assign in_motion = position_ff != target_ff;

   // Tick timing
   assign elapsed_inc = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + ELAPSED_BITS'(1);
   assign step_due    = (item_ff.func == FUNC_TICK) && in_motion &&
                        (TICK_CMP_BITS'(elapsed_inc) >=
                         TICK_CMP_BITS'(next_period_ff[PERIOD_BITS-1:PERIOD_FRAC_BITS]));

   // Step update of position and period
   assign decel_next  = decelerating_ff | at_decel_ff;
   assign pos_stepped = moving_neg_ff ? position_ff - POSITION_BITS'(1)
                                      : position_ff + POSITION_BITS'(1);
   assign period_sum  = {1'b0, next_period_ff} + {1'b0, cube_rsp.delta};
   assign period_up   = period_sum[PERIOD_BITS] ? '1 : period_sum[PERIOD_BITS-1:0];
   assign period_down = (cube_rsp.delta >= next_period_ff) ? '0
                                                           : next_period_ff - cube_rsp.delta;
   assign period_ramp    = decel_next ? period_up : period_down;
   assign period_clamped = (period_ramp < cruise_period_ff) ? cruise_period_ff : period_ramp;

   // Deceleration distance for a new move and target for a stop
   assign short_move  = SPAN_BITS'(abs_dist_ff) <= (SPAN_BITS'(full_decel_ff) << 1);
   assign decel_move  = short_move ? DECEL_BITS'(abs_dist_ff[POSITION_BITS-1:1])
                                   : DECEL_BITS'(full_decel_ff);
   assign stop_offset = POSITION_BITS'(decel_point_ff);

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Configuration writes
   always_comb begin
      start_period_in  = start_period_ff;
      cruise_period_in = cruise_period_ff;
      full_decel_in    = full_decel_ff;
      accel_coef_in    = accel_coef_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_START_PERIOD:  start_period_in  = csr_data[PERIOD_BITS-1:0];
            CSR_CRUISE_PERIOD: cruise_period_in = csr_data[PERIOD_BITS-1:0];
            CSR_DECEL_STEPS:   full_decel_in    = csr_data[DECEL_STEPS_BITS-1:0];
            CSR_ACCEL_COEF:    accel_coef_in    = csr_data[COEF_BITS-1:0];
            default:           start_period_in  = start_period_ff;
         endcase
      end
   end

   // Sequencer: decide, run the multiplier if a step is due, then commit
   always_comb begin
      state_in        = state_ff;
      item_in         = item_ff;
      step_in         = step_ff;
      at_decel_in     = at_decel_ff;
      dist_neg_in     = dist_neg_ff;
      abs_dist_in     = abs_dist_ff;
      position_in     = position_ff;
      target_in       = target_ff;
      moving_neg_in   = moving_neg_ff;
      decel_point_in  = decel_point_ff;
      next_period_in  = next_period_ff;
      last_period_in  = last_period_ff;
      elapsed_in      = elapsed_ff;
      decelerating_in = decelerating_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_load        = 1'b0;
      req_ready       = 1'b0;
      cube_req.start  = 1'b0;
      cube_req.period = next_period_ff;
      cube_req.coef   = accel_coef_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               item_in  = req_data;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            step_in     = step_due;
            at_decel_in = at_decel;
            dist_neg_in = dist_neg;
            abs_dist_in = abs_dist;
            if (step_due) begin
               cube_req.start = 1'b1;
               state_in       = ST_MUL_WAIT;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_MUL_WAIT: begin
            if (cube_rsp.done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (slot_free) begin
               unique case (item_ff.func)
                  FUNC_TICK: begin
                     if (step_ff) begin
                        decelerating_in = decel_next;
                        position_in     = pos_stepped;
                        next_period_in  = period_clamped;
                        last_period_in  = (pos_stepped == target_ff) ? '0 : next_period_ff;
                        elapsed_in      = '0;
                     end else if (in_motion) begin
                        elapsed_in = elapsed_inc;
                     end
                  end
                  FUNC_MOVE: begin
                     target_in       = item_pos;
                     moving_neg_in   = dist_neg_ff;
                     decel_point_in  = decel_move;
                     next_period_in  = start_period_ff;
                     decelerating_in = 1'b0;
                     elapsed_in      = '0;
                  end
                  FUNC_STOP: begin
                     if (in_motion) begin
                        target_in = moving_neg_ff ? position_ff - stop_offset
                                                  : position_ff + stop_offset;
                     end
                  end
                  FUNC_SET: begin
                     position_in = item_pos;
                  end
                  default: begin
                     position_in = position_ff;
                  end
               endcase
               rsp_valid_in = 1'b1;
               rsp_load     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result item from the committed state
   assign pos_sext       = {{32{position_in[POSITION_BITS-1]}}, position_in};
   assign period_int_out = OUT_CMP_BITS'(last_period_in[PERIOD_BITS-1:PERIOD_FRAC_BITS]);

   always_comb begin
      rsp_next.step_pulse      = (item_ff.func == FUNC_TICK) && step_ff;
      rsp_next.dir_negative    = moving_neg_in;
      rsp_next.position_now    = pos_sext[31:0];
      rsp_next.done_res        = position_in == target_in;
      rsp_next.step_period_now =
         (period_int_out > OUT_CMP_BITS'(STEP_PERIOD_MAX)) ? STEP_PERIOD_MAX
                                                         : period_int_out[STEP_PERIOD_BITS-1:0];
   end

   // Load the result register on commit, hold it otherwise
   assign rsp_data_in = rsp_load ? rsp_next : rsp_data_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Control, motion and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         position_ff      <= '0;
         target_ff        <= '0;
         moving_neg_ff    <= 1'b0;
         decel_point_ff   <= '0;
         next_period_ff   <= '0;
         last_period_ff   <= '0;
         elapsed_ff       <= '0;
         decelerating_ff  <= 1'b0;
         start_period_ff  <= START_PERIOD_RESET;
         cruise_period_ff <= CRUISE_PERIOD_RESET;
         full_decel_ff    <= DECEL_STEPS_RESET;
         accel_coef_ff    <= ACCEL_COEF_RESET;
      end else begin
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         position_ff      <= position_in;
         target_ff        <= target_in;
         moving_neg_ff    <= moving_neg_in;
         decel_point_ff   <= decel_point_in;
         next_period_ff   <= next_period_in;
         last_period_ff   <= last_period_in;
         elapsed_ff       <= elapsed_in;
         decelerating_ff  <= decelerating_in;
         start_period_ff  <= start_period_in;
         cruise_period_ff <= cruise_period_in;
         full_decel_ff    <= full_decel_in;
         accel_coef_ff    <= accel_coef_in;
      end
   end

   // Item and result payload
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      step_ff     <= step_in;
      at_decel_ff <= at_decel_in;
      dist_neg_ff <= dist_neg_in;
      abs_dist_ff <= abs_dist_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// File: hdl/stramp_checker.sv
`include "assert_macros.svh"

module stramp_checker
   import stramp_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A stalled result holds
   `STRAMP_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))

   // Reset empties the output register
   `STRAMP_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_valid)

   // One item in flight: no acceptance on the cycle after one
   `STRAMP_ASSERT(a_one_item, clock, reset, req_valid && req_ready |=> !req_ready)

   // A step that arrives at the target reports a stopped period
   `STRAMP_ASSERT(a_arrive_period, clock, reset, rsp_valid && rsp_data.step_pulse && rsp_data.done_res |-> rsp_data.step_period_now == '0)

endmodule

bind stepper_trapezoid_ramp stramp_checker u_stramp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// File: tb/stepper_trapezoid_ramp_checker.sv
module stepper_trapezoid_ramp_checker
   import stramp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  req_type                   req_data,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  rsp_type                   rsp_data,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   output int                        error_count,
   output int                        outstanding,
   output logic                      at_rest
);
   timeunit 1ns;
   timeprecision 1ps;

   // Register copies
   logic [PERIOD_BITS-1:0]      start_per;
   logic [PERIOD_BITS-1:0]      cruise_per;
   logic [DECEL_STEPS_BITS-1:0] brake_steps;
   logic [COEF_BITS-1:0]        coef;

   // Motion state
   logic [31:0]             pos_q;
   logic [31:0]             tgt_q;
   logic [31:0]             decel_pt;
   logic [PERIOD_BITS-1:0]  next_per;
   logic [PERIOD_BITS-1:0]  last_per;
   logic [ELAPSED_BITS-1:0] elapsed;
   logic                    neg_dir;
   logic                    braking;

   rsp_type expected_q[$];
   int      fails = 0;

   // Ramp term a*p^3 back in period units, saturated to the period width
   function automatic logic [PERIOD_BITS-1:0] ramp_term(input logic [PERIOD_BITS-1:0] p,
                                                        input logic [COEF_BITS-1:0] a);
      logic [159:0] prod;
      prod = 160'(p) * 160'(p) * 160'(p) * 160'(a);
      if (prod[159:RAMP_SHIFT+PERIOD_BITS] != '0) begin
         return '1;
      end
      return prod[RAMP_SHIFT +: PERIOD_BITS];
   endfunction

   // Advance the motion state by one item and return the result it produces
   function automatic rsp_type predict(input req_type item);
      logic [32:0]            travel;
      logic [32:0]            span;
      logic [31:0]            remain;
      logic [PERIOD_BITS-1:0] delta;
      logic [PERIOD_BITS-1:0] per;
      logic [PERIOD_BITS:0]   sum;
      rsp_type                res;
      res = '0;
      case (item.func)
         FUNC_TICK: begin
            if (pos_q != tgt_q) begin
               if (elapsed != '1) begin
                  elapsed = elapsed + 1'b1;
               end
               if (elapsed >= ELAPSED_BITS'(next_per[PERIOD_BITS-1:PERIOD_FRAC_BITS])) begin
                  // step, then bend the period toward cruise or back up
                  remain = neg_dir ? pos_q - tgt_q : tgt_q - pos_q;
                  if (remain == decel_pt) begin
                     braking = 1'b1;
                  end
                  pos_q = neg_dir ? pos_q - 32'd1 : pos_q + 32'd1;
                  last_per = next_per;
                  delta = ramp_term(next_per, coef);
                  if (braking) begin
                     sum = {1'b0, next_per} + {1'b0, delta};
                     per = sum[PERIOD_BITS] ? '1 : sum[PERIOD_BITS-1:0];
                  end else begin
                     per = (delta >= next_per) ? '0 : next_per - delta;
                  end
                  if (per < cruise_per) begin
                     per = cruise_per;
                  end
                  next_per = per;
                  if (pos_q == tgt_q) begin
                     last_per = '0;
                  end
                  elapsed = '0;
                  res.step_pulse = 1'b1;
               end
            end
         end
         FUNC_MOVE: begin
            travel = {item.position_value[31], item.position_value} - {pos_q[31], pos_q};
            tgt_q = item.position_value;
            neg_dir = travel[32];
            span = travel[32] ? -travel : travel;
            decel_pt = 32'(brake_steps);
            // short travel: brake halfway
            if (span <= {1'b0, brake_steps, 1'b0}) begin
               decel_pt = span[32:1];
            end
            next_per = start_per;
            braking = 1'b0;
            elapsed = '0;
         end
         FUNC_STOP: begin
            if (pos_q != tgt_q) begin
               tgt_q = neg_dir ? pos_q - decel_pt : pos_q + decel_pt;
            end
         end
         default: begin
            pos_q = item.position_value;
         end
      endcase
      res.dir_negative = neg_dir;
      res.position_now = pos_q;
      res.done_res = (pos_q == tgt_q);
      res.step_period_now = last_per[PERIOD_BITS-1:PERIOD_FRAC_BITS];
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      logic    bad;
      if (reset) begin
         start_per = START_PERIOD_RESET;
         cruise_per = CRUISE_PERIOD_RESET;
         brake_steps = DECEL_STEPS_RESET;
         coef = ACCEL_COEF_RESET;
         pos_q = '0;
         tgt_q = '0;
         decel_pt = '0;
         next_per = '0;
         last_per = '0;
         elapsed = '0;
         neg_dir = 1'b0;
         braking = 1'b0;
         expected_q.delete();
      end else begin
         // retire a result against the oldest expectation
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               if (fails < 10) begin
                  $display("result with none expected: %p", rsp_data);
               end
               fails++;
            end else begin
               want = expected_q.pop_front();
               bad = (rsp_data.step_pulse !== want.step_pulse) ||
                     (rsp_data.dir_negative !== want.dir_negative) ||
                     (rsp_data.position_now !== want.position_now) ||
                     (rsp_data.done_res !== want.done_res) ||
                     (rsp_data.step_period_now !== want.step_period_now);
               if (bad) begin
                  if (fails < 10) begin
                     $display("mismatch: expected step %0b dir %0b pos %0d done %0b period %0d",
                              want.step_pulse, want.dir_negative, want.position_now,
                              want.done_res, want.step_period_now);
                     $display("          got      step %0b dir %0b pos %0d done %0b period %0d",
                              rsp_data.step_pulse, rsp_data.dir_negative,
                              rsp_data.position_now, rsp_data.done_res,
                              rsp_data.step_period_now);
                  end
                  fails++;
               end
            end
         end
         // track register writes
         if (csr_we) begin
            case (csr_index)
               CSR_START_PERIOD:  start_per = csr_data[PERIOD_BITS-1:0];
               CSR_CRUISE_PERIOD: cruise_per = csr_data[PERIOD_BITS-1:0];
               CSR_DECEL_STEPS:   brake_steps = csr_data[DECEL_STEPS_BITS-1:0];
               CSR_ACCEL_COEF:    coef = csr_data[COEF_BITS-1:0];
            endcase
         end
         // queue the result of each accepted item
         if (req_valid && req_ready) begin
            expected_q.push_back(predict(req_data));
         end
      end
      error_count <= fails;
      outstanding <= expected_q.size();
      at_rest <= (pos_q == tgt_q);
   end

endmodule

// File: tb/stepper_trapezoid_ramp_tb.sv
module stepper_trapezoid_ramp_tb
   import stramp_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 800000;
   localparam int DRAIN_CYCLES = 80;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   req_type                   req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b1;
   rsp_type                   rsp_data;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   int          error_count;
   int          outstanding;
   logic        at_rest;
   logic        calm = 1'b0;
   int          cycle_count = 0;
   int          stall_left = 0;
   int          phase_items = 0;
   logic [31:0] aim = '0;

   stepper_trapezoid_ramp dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   stepper_trapezoid_ramp_checker motion_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .error_count (error_count),
      .outstanding (outstanding),
      .at_rest     (at_rest)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Stall the result side in random bursts
   always @(posedge clock) begin
      if (calm) begin
         rsp_ready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if (rsp_ready && $urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         stall_left <= $urandom_range(0, 12);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Offer one item, with an optional gap first, and hold it until accepted
   task automatic send_item(input func_type f, input logic [31:0] v);
      int      gap;
      req_type item;
      item.func = f;
      item.position_value = v;
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 13);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      phase_items++;
      if (f == FUNC_MOVE || f == FUNC_SET) begin
         aim = v;
      end
   endtask

   // Drop valid and hold until every expected result has come back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic load_config(input logic [CSR_DATA_BITS-1:0] start_v,
                              input logic [CSR_DATA_BITS-1:0] cruise_v,
                              input logic [CSR_DATA_BITS-1:0] steps_v,
                              input logic [CSR_DATA_BITS-1:0] coef_v);
      csr_we <= 1'b1;
      csr_index <= CSR_START_PERIOD;
      csr_data <= start_v;
      @(posedge clock);
      csr_index <= CSR_CRUISE_PERIOD;
      csr_data <= cruise_v;
      @(posedge clock);
      csr_index <= CSR_DECEL_STEPS;
      csr_data <= steps_v;
      @(posedge clock);
      csr_index <= CSR_ACCEL_COEF;
      csr_data <= coef_v;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Mostly full moves with random stops and retargets, some noise items
   task automatic run_phase(input int budget, input int span_max);
      int          cap;
      int          n;
      logic [31:0] v;
      phase_items = 0;
      while (phase_items < budget) begin
         if ($urandom_range(0, 9) < 7) begin
            if ($urandom_range(0, 1) == 0) begin
               case ($urandom_range(0, 3))
                  0:       v = $urandom();
                  1:       v = 32'h7FFF_FFFF - $urandom_range(0, 40);
                  2:       v = 32'h8000_0000 + $urandom_range(0, 40);
                  default: v = $urandom_range(0, 200) - 32'd100;
               endcase
               send_item(FUNC_SET, v);
            end
            if ($urandom_range(0, 9) == 0) begin
               v = $urandom();
            end else begin
               v = aim + $urandom_range(0, 2 * span_max) - 32'(span_max);
            end
            send_item(FUNC_MOVE, v);
            cap = $urandom_range(20, 250);
            n = 0;
            while (n < cap && !(at_rest && n > 2)) begin
               case ($urandom_range(0, 99))
                  0, 1, 2: send_item(FUNC_STOP, $urandom());
                  3:       send_item(FUNC_SET, aim + $urandom_range(0, 16) - 32'd8);
                  4:       send_item(FUNC_MOVE, aim + $urandom_range(0, 2 * span_max)
                                     - 32'(span_max));
                  default: send_item(FUNC_TICK, $urandom());
               endcase
               n++;
            end
         end else begin
            repeat ($urandom_range(1, 4)) send_item(func_type'($urandom_range(0, 3)), $urandom());
         end
      end
      settle();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: fast ramp, idle commands, extreme positions, wrap, stop, reverse
      load_config(CSR_DATA_BITS'(36'h1_8000), CSR_DATA_BITS'(36'h1_0000),
                  CSR_DATA_BITS'(2), CSR_DATA_BITS'(40'd50_000_000_000));
      send_item(FUNC_TICK, 32'h0000_0000);
      send_item(FUNC_STOP, 32'hFFFF_FFFF);
      send_item(FUNC_SET, 32'h7FFF_FFFF);
      send_item(FUNC_SET, 32'h8000_0000);
      send_item(FUNC_MOVE, 32'h7FFF_FFFF);
      repeat (2) send_item(FUNC_TICK, 32'h5555_AAAA);
      send_item(FUNC_SET, 32'd0);
      send_item(FUNC_MOVE, 32'd3);
      send_item(FUNC_TICK, 32'hAAAA_5555);
      send_item(FUNC_SET, 32'h7FFF_FFFE);
      repeat (3) send_item(FUNC_TICK, 32'h0000_0000);
      send_item(FUNC_SET, 32'd3);
      send_item(FUNC_TICK, 32'h0000_0000);
      send_item(FUNC_MOVE, 32'd20);
      repeat (3) send_item(FUNC_TICK, 32'h0000_0000);
      send_item(FUNC_STOP, 32'h0000_0000);
      repeat (5) send_item(FUNC_TICK, 32'h0000_0000);
      send_item(FUNC_MOVE, 32'hFFFF_FFF0);
      repeat (3) send_item(FUNC_TICK, 32'h0000_0000);
      settle();

      // Smallest periods, longest brake distance, steepest ramp
      load_config(CSR_DATA_BITS'(1), CSR_DATA_BITS'(1),
                  CSR_DATA_BITS'(31'h7FFF_FFFF), '1);
      run_phase(150, 20);

      // Largest periods, no brake distance, flattest ramp
      load_config(CSR_DATA_BITS'(36'hF_FFFF_FFFF), CSR_DATA_BITS'(36'hF_FFFF_FFFF),
                  CSR_DATA_BITS'(0), CSR_DATA_BITS'(1));
      run_phase(60, 20);

      // Fast start, cruise pinned at the top
      load_config(CSR_DATA_BITS'(36'h5_0000), CSR_DATA_BITS'(36'hF_FFFF_FFFF),
                  CSR_DATA_BITS'(3), CSR_DATA_BITS'({8'($urandom_range(0, 200)), $urandom()}));
      run_phase(80, 10);

      // Raw random register words, upper bits included
      load_config(CSR_DATA_BITS'({$urandom(), $urandom()}),
                  CSR_DATA_BITS'({$urandom(), $urandom()}),
                  CSR_DATA_BITS'({$urandom(), $urandom()}),
                  CSR_DATA_BITS'({$urandom(), $urandom()}));
      run_phase(60, 10);

      // Typical ramps; the last phase runs without idling
      for (int ph = 0; ph < 5; ph++) begin
         calm <= (ph == 2 || ph == 4);
         load_config(CSR_DATA_BITS'((36'($urandom_range(1, 12)) << PERIOD_FRAC_BITS)
                                    | 36'($urandom_range(0, 65535))),
                     CSR_DATA_BITS'((36'($urandom_range(0, 3)) << PERIOD_FRAC_BITS)
                                    | 36'($urandom_range(1, 65535))),
                     CSR_DATA_BITS'($urandom_range(0, 12)),
                     CSR_DATA_BITS'({8'($urandom_range(0, 200)), $urandom()}));
         run_phase(280, 24);
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+hdl
hdl/stramp_pkg.sv
hdl/stramp_cube_mul.sv
hdl/stepper_trapezoid_ramp.sv
hdl/stramp_checker.sv
tb/stepper_trapezoid_ramp_checker.sv
tb/stepper_trapezoid_ramp_tb.sv
